// File: rtl/core/rcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_pkg: shared types, constants and tables of the roll filter
// Register indexes, CORDIC step count and the arctangent table.
// ----------------------------------------------------------------------------
package rcf_pkg;

  localparam int CordicSteps = 16;
  localparam int FractionBits = 16;
  localparam int TableLen = 24;
  localparam int Steps = (CordicSteps < TableLen) ? CordicSteps : TableLen;
  localparam int ShiftW = $clog2(Steps);
  localparam int VecW = 34;
  localparam int AngW = FractionBits + 10;
  localparam logic signed [31:0] AccLimit = 32'sd11796480;

  localparam logic [2:0] RegFusionWeight = 3'd0;
  localparam logic [2:0] RegLowpassAlpha = 3'd1;
  localparam logic [2:0] RegSamplePeriod = 3'd2;
  localparam logic [2:0] RegGyroScale = 3'd3;
  localparam logic [2:0] RegAccelYBias = 3'd4;
  localparam logic [2:0] RegAccelZBias = 3'd5;
  localparam logic [2:0] RegGyroXBias = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_MATH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] z;
  } cordic_t;

  function automatic logic signed [AngW-1:0] atan_entry(input int i);
    logic signed [31:0] t;
    logic signed [31:0] r;
    case (i)
      0: t = 32'sd754974720;  1: t = 32'sd445687602;
      2: t = 32'sd235489088;  3: t = 32'sd119537938;
      4: t = 32'sd60000934;   5: t = 32'sd30029717;
      6: t = 32'sd15018523;   7: t = 32'sd7509720;
      8: t = 32'sd3754917;    9: t = 32'sd1877466;
      10: t = 32'sd938734;    11: t = 32'sd469367;
      12: t = 32'sd234684;    13: t = 32'sd117342;
      14: t = 32'sd58671;     15: t = 32'sd29335;
      16: t = 32'sd14668;     17: t = 32'sd7334;
      18: t = 32'sd3667;      19: t = 32'sd1833;
      20: t = 32'sd917;       21: t = 32'sd458;
      22: t = 32'sd229;       23: t = 32'sd115;
      default: t = 32'sd0;
    endcase
    if (FractionBits >= 24) begin
      r = t;
    end else begin
      r = (t + (32'sd1 <<< (23 - FractionBits))) >>> (24 - FractionBits);
    end
    return AngW'(r);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// File: rtl/core/rcf_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_stream_if: valid/ready channels of the roll filter
// Input sample, result and configuration write channels.
// ----------------------------------------------------------------------------
interface rcf_sample_if;
  logic valid;
  logic ready;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  modport source(output valid, accel_y, accel_z, gyro_x, input ready);
  modport sink(input valid, accel_y, accel_z, gyro_x, output ready);
endinterface

interface rcf_result_if;
  logic valid;
  logic ready;
  logic signed [24:0] roll_accel;
  logic signed [31:0] roll_integrated;
  logic signed [31:0] roll_fused;
  logic signed [31:0] rate_filtered;
  modport source(output valid, roll_accel, roll_integrated, roll_fused, rate_filtered,
                 input ready);
  modport sink(input valid, roll_accel, roll_integrated, roll_fused, rate_filtered,
               output ready);
endinterface

interface rcf_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/core/rcf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_cell: one CORDIC vectoring micro-rotation
// Rotate toward the x axis by the shift tied at the port and register it.
// ----------------------------------------------------------------------------
module rcf_cell (
  input  logic                        clk,
  input  logic [rcf_pkg::ShiftW-1:0]  shift,
  input  rcf_pkg::cordic_t            din,
  output rcf_pkg::cordic_t            dout
);

  rcf_pkg::cordic_t nxt;

  always_comb begin
    if (!din.y[rcf_pkg::VecW-1]) begin
      nxt.x = din.x + (din.y >>> shift);
      nxt.y = din.y - (din.x >>> shift);
      nxt.z = din.z + rcf_pkg::atan_entry(int'(shift));
    end else begin
      nxt.x = din.x - (din.y >>> shift);
      nxt.y = din.y + (din.x >>> shift);
      nxt.z = din.z - rcf_pkg::atan_entry(int'(shift));
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule

// File: rtl/core/rcf_cordic_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_cordic_chain: row of CORDIC cells
// Pre-rotate into the right half-plane, then pass through the cells.
// ----------------------------------------------------------------------------
module rcf_cordic_chain (
  input  logic                       clk,
  input  logic signed [16:0]         ay,
  input  logic signed [16:0]         az,
  output logic signed [rcf_pkg::AngW-1:0] angle
);

  rcf_pkg::cordic_t stage [rcf_pkg::Steps+1];
  rcf_pkg::cordic_t head;
  logic signed [rcf_pkg::VecW-1:0] vx, vy;

  always_comb begin
    vx = rcf_pkg::VecW'(az) <<< 14;
    vy = rcf_pkg::VecW'(ay) <<< 14;
    head.x = vx;
    head.y = vy;
    head.z = '0;
    if (vx[rcf_pkg::VecW-1]) begin
      if (!vy[rcf_pkg::VecW-1]) begin
        head.x = vy;
        head.y = -vx;
        head.z = rcf_pkg::AngW'(90) <<< rcf_pkg::FractionBits;
      end else begin
        head.x = -vy;
        head.y = vx;
        head.z = -(rcf_pkg::AngW'(90) <<< rcf_pkg::FractionBits);
      end
    end
  end

  always_ff @(posedge clk) begin
    stage[0] <= head;
  end

  for (genvar i = 0; i < rcf_pkg::Steps; i++) begin : g_cell
    rcf_cell u_cell (
      .clk  (clk),
      .shift(rcf_pkg::ShiftW'(i)),
      .din  (stage[i]),
      .dout (stage[i+1])
    );
  end

  assign angle = stage[rcf_pkg::Steps].z;

endmodule

// File: rtl/core/roll_complementary_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roll_complementary_filter: IMU roll estimator
// Bias, CORDIC atan2 roll, gyro integration, fusion and rate low-pass.
// ----------------------------------------------------------------------------
// One sample at a time: a beat is taken and its biased sums latched, then they
// walk one pre-rotation stage and a chain of 16 CORDIC cells (one per cycle),
// then on leaving the run state the clamped angle and the scaled rate are captured, then
// the filter math forms the angle step and then updates the integrator, fusion
// and low-pass outputs, and the result beat waits in the output register. Most
// of the delay to a valid result comes from the cell chain. A new sample is
// taken the cycle after the result is taken, and none before that.
// Configuration writes are always ready; unknown indexes are dropped.
module roll_complementary_filter (
  input logic         clk,
  input logic         rst,
  rcf_sample_if.sink  sample,
  rcf_result_if.source result,
  rcf_cfg_if.sink     cfg
);

  logic [15:0] fusion_weight, lowpass_alpha, sample_period, gyro_scale;
  logic signed [15:0] accel_y_bias, accel_z_bias, gyro_x_bias;
  logic signed [31:0] integrated_angle, fused_angle, filtered_rate;

  rcf_pkg::state_t state, state_next;
  logic [4:0] count;
  logic signed [16:0] ay, az, g;
  logic signed [rcf_pkg::AngW-1:0] angle;
  logic signed [31:0] rate;
  logic signed [24:0] acc_roll;
  logic signed [63:0] delta;
  logic signed [63:0] q;

  assign cfg.ready = 1'b1;
  assign sample.ready = (state == rcf_pkg::ST_IDLE);
  assign result.valid = (state == rcf_pkg::ST_OUT);

  // Hold registers; write on a config beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      fusion_weight <= 16'd64225;
      lowpass_alpha <= 16'd19661;
      sample_period <= 16'd655;
      gyro_scale <= 16'd1998;
      accel_y_bias <= -16'sd15;
      accel_z_bias <= -16'sd759;
      gyro_x_bias <= 16'sd195;
    end else if (cfg.valid) begin
      case (cfg.index)
        rcf_pkg::RegFusionWeight: fusion_weight <= cfg.data;
        rcf_pkg::RegLowpassAlpha: lowpass_alpha <= cfg.data;
        rcf_pkg::RegSamplePeriod: sample_period <= cfg.data;
        rcf_pkg::RegGyroScale: gyro_scale <= cfg.data;
        rcf_pkg::RegAccelYBias: accel_y_bias <= cfg.data;
        rcf_pkg::RegAccelZBias: accel_z_bias <= cfg.data;
        rcf_pkg::RegGyroXBias: gyro_x_bias <= cfg.data;
        default: ;
      endcase
    end
  end

  rcf_cordic_chain u_chain (.clk(clk), .ay(ay), .az(az), .angle(angle));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rcf_pkg::ST_IDLE: if (sample.valid) state_next = rcf_pkg::ST_RUN;
      rcf_pkg::ST_RUN: if (count == 5'(rcf_pkg::Steps + 1)) state_next = rcf_pkg::ST_MATH;
      rcf_pkg::ST_MATH: if (count == 5'd1) state_next = rcf_pkg::ST_OUT;
      rcf_pkg::ST_OUT: if (result.ready) state_next = rcf_pkg::ST_IDLE;
      default: state_next = rcf_pkg::ST_IDLE;
    endcase
  end

  // Map the CORDIC angle to Q16.16 with clamp; special axes override.
  always_comb begin
    if (rcf_pkg::FractionBits >= 16) begin
      q = (64'(angle) + ((64'sd1 <<< rcf_pkg::FractionBits) >>> 17))
          >>> (rcf_pkg::FractionBits - 16);
    end else begin
      q = 64'(angle) <<< (16 - rcf_pkg::FractionBits);
    end
    if (ay == 17'sd0) begin
      q = az[16] ? 64'(rcf_pkg::AccLimit) : 64'sd0;
    end else if (az == 17'sd0) begin
      q = ay[16] ? -64'(rcf_pkg::AccLimit >>> 1) : 64'(rcf_pkg::AccLimit >>> 1);
    end
    if (q > 64'(rcf_pkg::AccLimit)) q = 64'(rcf_pkg::AccLimit);
    if (q < -64'(rcf_pkg::AccLimit)) q = -64'(rcf_pkg::AccLimit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      integrated_angle <= '0;
      fused_angle <= '0;
      filtered_rate <= '0;
    end else begin
      case (state)
        rcf_pkg::ST_IDLE: begin
          count <= '0;
          if (sample.valid) begin
            ay <= 17'(sample.accel_y) + 17'(accel_y_bias);
            az <= 17'(sample.accel_z) + 17'(accel_z_bias);
            g <= 17'(sample.gyro_x) + 17'(gyro_x_bias);
          end
        end
        rcf_pkg::ST_RUN: begin
          count <= (state_next == rcf_pkg::ST_MATH) ? 5'd0 : count + 5'd1;
          if (state_next == rcf_pkg::ST_MATH) begin
            acc_roll <= q[24:0];
            rate <= rcf_pkg::sat32(64'(g) * $signed({1'b0, gyro_scale}));
          end
        end
        rcf_pkg::ST_MATH: begin
          count <= count + 5'd1;
          if (count == 5'd0) begin
            delta <= (64'(rate) * $signed({1'b0, sample_period}) + 64'sd32768) >>> 16;
          end else begin
            integrated_angle <= rcf_pkg::sat32(64'(integrated_angle) + delta);
            fused_angle <= rcf_pkg::sat32(
                ($signed({1'b0, fusion_weight}) * (64'(fused_angle) + delta)
                 + (64'sd65536 - $signed({1'b0, fusion_weight})) * 64'(acc_roll)
                 + 64'sd32768) >>> 16);
            filtered_rate <= rcf_pkg::sat32(
                ($signed({1'b0, lowpass_alpha}) * 64'(filtered_rate)
                 + (64'sd65536 - $signed({1'b0, lowpass_alpha})) * 64'(rate)
                 + 64'sd32768) >>> 16);
          end
        end
        default: ;
      endcase
    end
  end

  assign result.roll_accel = acc_roll;
  assign result.roll_integrated = integrated_angle;
  assign result.roll_fused = fused_angle;
  assign result.rate_filtered = filtered_rate;

endmodule
